[sv/lifo_stack_with_search_delete_macros.svh]
// assertion macros for the lifo stack with search and delete
// used by the top level; no other dependencies
`ifndef LIFO_STACK_WITH_SEARCH_DELETE_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_DELETE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define LSD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (cond)) \
		else $error("lsd assertion failed");

// condition that must hold in the cycle after the trigger
`define LSD_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("lsd assertion failed");

`endif

[sv/lsd_pkg.sv]
// shared types and constants of the lifo stack with search and delete
// no dependencies; used by lsd_cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package lsd_pkg;

	localparam int Depth = 64;
	localparam int DataW = 32;
	localparam int CntW  = $clog2(Depth + 1);
	localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int PosW  = 7;

	// operation codes of an input item
	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_FIND   = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic             push;
		logic             pop;
		logic             remove;
		logic [DataW-1:0] key;
	} lsd_ctl_t;

endpackage

`default_nettype wire

[sv/lsd_cell.sv]
// one cell of the stack row: holds one entry, compares it with the key
// and shifts towards or away from the top; depends on lsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsd_cell (
	input  wire                           clk,
	input  lsd_pkg::lsd_ctl_t             ctl,
	input  wire                           valid,
	input  wire                           seen_in,
	input  wire  [lsd_pkg::DataW-1:0]     above_value,
	input  wire  [lsd_pkg::DataW-1:0]     below_value,
	output logic [lsd_pkg::DataW-1:0]     value,
	output logic                          seen_out
);

	logic [lsd_pkg::DataW-1:0] value_q;
	logic                      match;

	// compare against the key, ripple the first-match mark downwards
	assign match    = valid && (value_q == ctl.key);
	assign seen_out = seen_in || match;
	assign value    = value_q;

	// push shifts down, pop shifts up, remove closes the gap below the match
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			value_q <= above_value;
		end else if (ctl.pop) begin
			value_q <= below_value;
		end else if (ctl.remove && seen_out) begin
			value_q <= below_value;
		end
	end

endmodule

`default_nettype wire

[sv/lifo_stack_with_search_delete.sv]
// Bounded LIFO store of signed 32-bit values with push, pop, find and remove.
// Entries live in a row of cells with the top in cell 0; every operation is
// one compare-and-shift pass through the row, done after the item is accepted
// and once the output register is free or being taken, and its result is
// held in an output register. One item is accepted per cycle while results
// are taken, so the sustained rate is then one item per cycle.
// The store needs no clearing after reset; only occupied cells are read.
// Depends on lsd_pkg, lsd_cell and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "lifo_stack_with_search_delete_macros.svh"

module lifo_stack_with_search_delete (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [1:0]                       operation,
	input  wire  signed [lsd_pkg::DataW-1:0] operand_value,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic signed [lsd_pkg::DataW-1:0] popped_value,
	output logic signed [lsd_pkg::PosW-1:0]  found_position,
	output logic [1:0]                       status,
	output logic [lsd_pkg::PosW-1:0]         entry_count
);

	localparam int Depth = lsd_pkg::Depth;
	localparam int DataW = lsd_pkg::DataW;
	localparam int CntW  = lsd_pkg::CntW;
	localparam int IdxW  = lsd_pkg::IdxW;
	localparam int PosW  = lsd_pkg::PosW;

	logic                 busy_q;
	lsd_pkg::op_t         op_q;
	logic [DataW-1:0]     key_q;
	logic [CntW-1:0]      count_q;
	logic                 out_valid_q;
	logic [DataW-1:0]     popped_q;
	logic [PosW-1:0]      pos_q;
	lsd_pkg::status_t     status_q;
	logic [PosW-1:0]      count_out_q;

	logic                 exec;
	logic                 accept;
	logic                 full;
	logic                 empty;
	logic                 found;
	lsd_pkg::lsd_ctl_t    ctl;
	logic [Depth:0]       seen;
	logic [Depth-1:0]     cell_valid;
	logic [DataW-1:0]     cell_value [Depth];
	logic [IdxW-1:0]      first_idx;
	logic [CntW-1:0]      count_next;
	logic [DataW-1:0]     popped_next;
	logic [PosW-1:0]      pos_next;
	lsd_pkg::status_t     status_next;

	// handshake: execute when the output register is free or being emptied
	assign exec     = busy_q && (!out_valid_q || out_ready);
	assign in_ready = !busy_q || exec;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);

	// command broadcast to the cell row
	always_comb begin
		ctl.push   = exec && (op_q == lsd_pkg::OP_PUSH) && !full;
		ctl.pop    = exec && (op_q == lsd_pkg::OP_POP) && !empty;
		ctl.remove = exec && (op_q == lsd_pkg::OP_REMOVE);
		ctl.key    = key_q;
	end

	// row of cells, top in cell 0
	assign seen[0] = 1'b0;
	generate
		for (genvar i = 0; i < Depth; i++) begin : g_cell
			logic [DataW-1:0] above_v;
			logic [DataW-1:0] below_v;
			assign cell_valid[i] = (CntW'(i) < count_q);
			if (i == 0) begin : g_top
				assign above_v = key_q;
			end else begin : g_mid
				assign above_v = cell_value[i-1];
			end
			if (i == Depth - 1) begin : g_bot
				assign below_v = '0;
			end else begin : g_up
				assign below_v = cell_value[i+1];
			end
			lsd_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.valid       (cell_valid[i]),
				.seen_in     (seen[i]),
				.above_value (above_v),
				.below_value (below_v),
				.value       (cell_value[i]),
				.seen_out    (seen[i+1])
			);
		end
	endgenerate

	assign found = seen[Depth];

	// encode the one-hot first match into its distance from the top
	always_comb begin
		first_idx = '0;
		for (int i = 0; i < Depth; i++) begin
			if (seen[i+1] && !seen[i]) begin
				first_idx = first_idx | IdxW'(i);
			end
		end
	end

	// result and new occupancy of the executing item
	always_comb begin
		count_next  = count_q;
		popped_next = '0;
		pos_next    = '0;
		status_next = lsd_pkg::ST_DONE;
		unique case (op_q)
			lsd_pkg::OP_PUSH: begin
				if (full) begin
					status_next = lsd_pkg::ST_FULL;
				end else begin
					count_next = count_q + CntW'(1);
				end
			end
			lsd_pkg::OP_POP: begin
				if (empty) begin
					popped_next = '1;
					status_next = lsd_pkg::ST_MISS;
				end else begin
					popped_next = cell_value[0];
					count_next  = count_q - CntW'(1);
				end
			end
			lsd_pkg::OP_FIND: begin
				if (found) begin
					pos_next = PosW'(first_idx);
				end else begin
					pos_next    = '1;
					status_next = lsd_pkg::ST_MISS;
				end
			end
			lsd_pkg::OP_REMOVE: begin
				if (found) begin
					count_next = count_q - CntW'(1);
				end else begin
					status_next = lsd_pkg::ST_MISS;
				end
			end
			default: begin
				status_next = lsd_pkg::ST_DONE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// accepted item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= lsd_pkg::op_t'(operation);
			key_q <= operand_value;
		end
		if (exec) begin
			popped_q    <= popped_next;
			pos_q       <= pos_next;
			status_q    <= status_next;
			count_out_q <= PosW'(count_next);
		end
	end

	assign out_valid      = out_valid_q;
	assign popped_value   = signed'(popped_q);
	assign found_position = signed'(pos_q);
	assign status         = status_q;
	assign entry_count    = count_out_q;

	// checks on occupancy bookkeeping and result hand-over
	`LSD_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CntW'(Depth))
	`LSD_ASSERT_NEXT(a_full_push_keeps_count, clk, arst_n, exec && (op_q == lsd_pkg::OP_PUSH) && full, count_q == $past(count_q))
	`LSD_ASSERT_NEXT(a_remove_hit_drops_one, clk, arst_n, exec && (op_q == lsd_pkg::OP_REMOVE) && found, count_q == $past(count_q) - CntW'(1))
	`LSD_ASSERT_NEXT(a_exec_gives_result, clk, arst_n, exec, out_valid_q && (entry_count == PosW'(count_q)))

endmodule

`default_nettype wire
